>>> rtl/edwu_pkg.sv
// ============================================================================
// edwu_pkg: shared types and constants of the error-diffusion weight update
// Request and result structs, command and register codes, operation kinds
// and the fixed-point constants of the update datapath.
// ============================================================================
`default_nettype none

package edwu_pkg;

    // Default sizes of the weight store
    localparam int EDWU_NUM_NETS    = 4;
    localparam int EDWU_NUM_NEURONS = 64;

    // Entries of the queue between front and back
    localparam int EDWU_QUEUE_DEPTH = 4;

    // Width of the operand that a job carries (load weight or update change)
    localparam int OPERAND_W = 34;

    // Register reset values
    localparam logic [15:0] RATE_RESET  = 16'd3277;
    localparam logic        BIDIR_RESET = 1'b0;

    // Command codes of a request (code 3 reads)
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] CFG_STEP_RATE  = 1'b0;
    localparam logic [0:0] CFG_BIDIR_MODE = 1'b1;

    // Q2.14 one and the saturation bounds of a Q8.24 weight
    localparam logic signed [16:0] DERIV_ONE  = 17'sd16384;
    localparam logic signed [31:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WEIGHT_MIN = 32'sh8000_0000;

    // Operation kind after classification
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_UPDATE,
        OP_READ
    } edwu_op_t;

    // One request
    typedef struct packed {
        logic        [1:0]  command;
        logic        [1:0]  net_index;
        logic        [5:0]  target_index;
        logic        [5:0]  source_index;
        logic signed [31:0] load_weight;
        logic signed [15:0] source_activation;
        logic signed [15:0] target_output;
        logic signed [15:0] error_excite;
        logic signed [15:0] error_inhibit;
        logic               source_negative;
        logic               target_negative;
    } edwu_in_t;

    // One result
    typedef struct packed {
        logic signed [31:0] weight_value;
        logic               was_updated;
        logic               saturated;
    } edwu_out_t;

    // Classified job handed from front to back
    typedef struct packed {
        edwu_op_t                     op;
        logic signed [OPERAND_W-1:0]  operand;
    } edwu_job_t;

endpackage

`default_nettype wire

>>> rtl/edwu_front.sv
// ============================================================================
// edwu_front: request intake, classification and update arithmetic
// Takes requests, checks the address range, forms the store address and
// computes the weight change of an update in four register stages.
// ============================================================================
`default_nettype none

module edwu_front
#(
    parameter int NUM_NETS    = edwu_pkg::EDWU_NUM_NETS,
    parameter int NUM_NEURONS = edwu_pkg::EDWU_NUM_NEURONS,
    parameter int ADDR_W      = 14
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 hold,
    input  wire logic [15:0]          step_rate,
    input  wire logic                 bidir_mode,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire edwu_pkg::edwu_in_t   in_data,
    input  wire logic                 queue_full,
    output logic                      push,
    output edwu_pkg::edwu_job_t       push_job,
    output logic [ADDR_W-1:0]         push_addr
);
    import edwu_pkg::*;

    logic adv;
    logic accept;

    // Stage valids
    logic f0_valid_reg;
    logic f1_valid_reg;
    logic f2_valid_reg;
    logic f3_valid_reg;

    // Stage 0: classified request
    edwu_op_t           op_next;
    logic [ADDR_W-1:0]  addr_next;
    logic               in_range;
    edwu_op_t           f0_op_reg;
    logic [ADDR_W-1:0]  f0_addr_reg;
    logic signed [31:0] f0_load_reg;
    logic signed [15:0] f0_act_reg;
    logic signed [15:0] f0_tout_reg;
    logic signed [15:0] f0_eex_reg;
    logic signed [15:0] f0_einh_reg;
    logic               f0_sneg_reg;
    logic               f0_tneg_reg;

    // Stage 1: derivative product, rate times activation, error term
    logic signed [16:0] tout_ext;
    logic signed [16:0] mag;
    logic signed [16:0] one_minus;
    logic signed [33:0] p_full;
    logic signed [30:0] p_next;
    logic signed [32:0] ra_next;
    logic signed [16:0] eex_ext;
    logic signed [16:0] einh_ext;
    logic signed [16:0] diff;
    logic signed [16:0] sel_err;
    logic signed [16:0] e_next;
    edwu_op_t           f1_op_reg;
    logic [ADDR_W-1:0]  f1_addr_reg;
    logic signed [31:0] f1_load_reg;
    logic signed [30:0] f1_p_reg;
    logic signed [32:0] f1_ra_reg;
    logic signed [16:0] f1_e_reg;

    // Stage 2: rate times activation times derivative
    logic signed [30:0] deriv_sum;
    logic signed [15:0] deriv;
    logic signed [48:0] prod2_full;
    logic signed [47:0] prod2_next;
    edwu_op_t           f2_op_reg;
    logic [ADDR_W-1:0]  f2_addr_reg;
    logic signed [31:0] f2_load_reg;
    logic signed [47:0] f2_prod_reg;
    logic signed [16:0] f2_e_reg;

    // Stage 3: delta times error
    logic signed [47:0] d24_sum;
    logic signed [31:0] d24;
    logic signed [48:0] prod3_full;
    logic signed [47:0] prod3_next;
    edwu_op_t           f3_op_reg;
    logic [ADDR_W-1:0]  f3_addr_reg;
    logic signed [31:0] f3_load_reg;
    logic signed [47:0] f3_prod_reg;

    // Push side: rounded change
    logic signed [47:0] change_sum;
    logic signed [OPERAND_W-1:0] change;

    // Advance the whole pipe unless the last stage cannot leave
    assign adv      = !(f3_valid_reg && queue_full);
    assign in_stall = hold || !adv;
    assign accept   = in_valid && !in_stall;
    assign push     = f3_valid_reg && !queue_full;

    // Classify the request and form the store address
    assign in_range = (32'(in_data.net_index) < 32'(NUM_NETS))
                   && (32'(in_data.target_index) < 32'(NUM_NEURONS))
                   && (32'(in_data.source_index) < 32'(NUM_NEURONS));

    assign addr_next = ADDR_W'((32'(in_data.net_index) * 32'(NUM_NEURONS)
                     + 32'(in_data.target_index)) * 32'(NUM_NEURONS)
                     + 32'(in_data.source_index));

    always_comb
    begin
        op_next = OP_NONE;
        if (in_range)
        begin
            unique case (in_data.command)
                CMD_LOAD:   op_next = OP_LOAD;
                CMD_UPDATE: op_next = OP_UPDATE;
                CMD_READ:   op_next = OP_READ;
                default:    op_next = OP_READ;
            endcase
        end
    end

    // Stage 1 arithmetic
    assign tout_ext  = {f0_tout_reg[15], f0_tout_reg};
    assign mag       = f0_tout_reg[15] ? -tout_ext : tout_ext;
    assign one_minus = DERIV_ONE - mag;
    assign p_full    = mag * one_minus;
    assign p_next    = p_full[30:0];
    assign ra_next   = $signed({1'b0, step_rate}) * f0_act_reg;

    assign eex_ext  = {f0_eex_reg[15], f0_eex_reg};
    assign einh_ext = {f0_einh_reg[15], f0_einh_reg};
    assign diff     = eex_ext - einh_ext;
    assign sel_err  = f0_sneg_reg ? einh_ext : eex_ext;

    always_comb
    begin
        if (bidir_mode)
        begin
            e_next = f0_tneg_reg ? -diff : diff;
        end
        else
        begin
            e_next = (f0_sneg_reg ^ f0_tneg_reg) ? -sel_err : sel_err;
        end
    end

    // Stage 2 arithmetic: round the derivative, then multiply
    assign deriv_sum  = f1_p_reg + 31'sd8192;
    assign deriv      = deriv_sum[29:14];
    assign prod2_full = f1_ra_reg * deriv;
    assign prod2_next = prod2_full[47:0];

    // Stage 3 arithmetic: round delta to Q.24, then multiply by error
    assign d24_sum    = f2_prod_reg + 48'sd32768;
    assign d24        = d24_sum[47:16];
    assign prod3_full = d24 * f2_e_reg;
    assign prod3_next = prod3_full[47:0];

    // Round the change and build the job
    assign change_sum = f3_prod_reg + 48'sd8192;
    assign change     = change_sum[47:14];

    always_comb
    begin
        push_job.op = f3_op_reg;
        if (f3_op_reg == OP_LOAD)
        begin
            push_job.operand = {{(OPERAND_W-32){f3_load_reg[31]}}, f3_load_reg};
        end
        else
        begin
            push_job.operand = change;
        end
    end

    assign push_addr = f3_addr_reg;

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f0_valid_reg <= accept;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_op_reg   <= op_next;
            f0_addr_reg <= addr_next;
            f0_load_reg <= in_data.load_weight;
            f0_act_reg  <= in_data.source_activation;
            f0_tout_reg <= in_data.target_output;
            f0_eex_reg  <= in_data.error_excite;
            f0_einh_reg <= in_data.error_inhibit;
            f0_sneg_reg <= in_data.source_negative;
            f0_tneg_reg <= in_data.target_negative;

            f1_op_reg   <= f0_op_reg;
            f1_addr_reg <= f0_addr_reg;
            f1_load_reg <= f0_load_reg;
            f1_p_reg    <= p_next;
            f1_ra_reg   <= ra_next;
            f1_e_reg    <= e_next;

            f2_op_reg   <= f1_op_reg;
            f2_addr_reg <= f1_addr_reg;
            f2_load_reg <= f1_load_reg;
            f2_prod_reg <= prod2_next;
            f2_e_reg    <= f1_e_reg;

            f3_op_reg   <= f2_op_reg;
            f3_addr_reg <= f2_addr_reg;
            f3_load_reg <= f2_load_reg;
            f3_prod_reg <= prod3_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/edwu_queue.sv
// ============================================================================
// edwu_queue: short job queue between front and back
// First-in first-out store of classified jobs with the head shown ahead,
// so the front and the back stall independently.
// ============================================================================
`default_nettype none

module edwu_queue
#(
    parameter int DEPTH  = edwu_pkg::EDWU_QUEUE_DEPTH,
    parameter int ADDR_W = 14
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire edwu_pkg::edwu_job_t  push_job,
    input  wire logic [ADDR_W-1:0]    push_addr,
    input  wire logic                 pop,
    output edwu_pkg::edwu_job_t       head_job,
    output logic [ADDR_W-1:0]         head_addr,
    output logic                      empty,
    output logic                      full
);
    import edwu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    edwu_job_t          job_reg  [DEPTH];
    logic [ADDR_W-1:0]  addr_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_job  = job_reg[rd_ptr_reg];
    assign head_addr = addr_reg[rd_ptr_reg];

    // Wrap the pointers at the queue depth
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_reg[wr_ptr_reg]  <= push_job;
            addr_reg[wr_ptr_reg] <= push_addr;
        end
    end

    // Never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("edwu_queue: push while full");

    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("edwu_queue: pop while empty");

endmodule

`default_nettype wire

>>> rtl/edwu_back.sv
// ============================================================================
// edwu_back: weight store, read-modify-write and result register
// Reads the addressed weight, applies the job with forwarding of the last
// write, saturates updates, writes back and holds the result for the output.
// ============================================================================
`default_nettype none

module edwu_back
#(
    parameter int NUM_NETS    = edwu_pkg::EDWU_NUM_NETS,
    parameter int NUM_NEURONS = edwu_pkg::EDWU_NUM_NEURONS,
    parameter int ADDR_W      = 14
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    output logic                      clearing,
    input  wire logic                 q_empty,
    input  wire edwu_pkg::edwu_job_t  q_job,
    input  wire logic [ADDR_W-1:0]    q_addr,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output edwu_pkg::edwu_out_t       out_data
);
    import edwu_pkg::*;

    localparam int DEPTH = NUM_NETS * NUM_NEURONS * NUM_NEURONS;

    // Weight store
    logic signed [31:0] weight_mem [DEPTH];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic signed [31:0] mem_wdata;

    // Clearing pass after reset
    logic               clr_busy_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    // Execute stage
    logic               b1_valid_reg;
    edwu_job_t          b1_job_reg;
    logic [ADDR_W-1:0]  b1_addr_reg;
    logic signed [31:0] rd_data_reg;
    logic               b1_adv;

    // Last write, for a read that crossed it
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic signed [31:0] fwd_data_reg;

    // Output register
    logic               out_valid_reg;
    edwu_out_t          out_reg;

    logic signed [31:0] weight;
    logic signed [34:0] upd_sum;
    logic               over_hi;
    logic               over_lo;
    logic signed [31:0] sat_value;
    logic               wr_req;
    logic signed [31:0] wr_data;
    edwu_out_t          res_next;

    assign clearing  = clr_busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Move the job on when the output register frees up
    assign b1_adv = b1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop    = !q_empty && !clr_busy_reg && (!b1_valid_reg || b1_adv);

    // Pick the current weight, forwarding the write that crossed the read
    assign weight = (fwd_valid_reg && (fwd_addr_reg == b1_addr_reg))
                  ? fwd_data_reg : rd_data_reg;

    // Add the change and saturate to the Q8.24 range
    assign upd_sum = {{3{weight[31]}}, weight}
                   + {{(35 - OPERAND_W){b1_job_reg.operand[OPERAND_W-1]}},
                      b1_job_reg.operand};
    assign over_hi = !upd_sum[34] && (upd_sum[33:31] != 3'b000);
    assign over_lo =  upd_sum[34] && (upd_sum[33:31] != 3'b111);

    always_comb
    begin
        if (over_hi)
        begin
            sat_value = WEIGHT_MAX;
        end
        else if (over_lo)
        begin
            sat_value = WEIGHT_MIN;
        end
        else
        begin
            sat_value = upd_sum[31:0];
        end
    end

    // Carry out the job
    always_comb
    begin
        wr_req   = 1'b0;
        wr_data  = weight;
        res_next = '0;
        unique case (b1_job_reg.op)
            OP_NONE:
            begin
                res_next = '0;
            end
            OP_LOAD:
            begin
                wr_req                = 1'b1;
                wr_data               = b1_job_reg.operand[31:0];
                res_next.weight_value = b1_job_reg.operand[31:0];
            end
            OP_UPDATE:
            begin
                // a zero weight is a disabled connection and stays zero
                if (weight != 32'sd0)
                begin
                    wr_req                = 1'b1;
                    wr_data               = sat_value;
                    res_next.weight_value = sat_value;
                    res_next.was_updated  = 1'b1;
                    res_next.saturated    = over_hi || over_lo;
                end
            end
            OP_READ:
            begin
                res_next.weight_value = weight;
            end
        endcase
    end

    // Share the write port between the clearing pass and the jobs
    assign mem_we    = clr_busy_reg || (b1_adv && wr_req);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : b1_addr_reg;
    assign mem_wdata = clr_busy_reg ? 32'sd0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            weight_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= weight_mem[q_addr];
        end
    end

    // Sweep the store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Track the execute stage, the last write and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                b1_valid_reg <= 1'b1;
            end
            else if (b1_adv)
            begin
                b1_valid_reg <= 1'b0;
            end

            if (b1_adv && wr_req)
            begin
                fwd_valid_reg <= 1'b1;
            end

            if (b1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold job, forwarding and result payloads
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_job_reg  <= q_job;
            b1_addr_reg <= q_addr;
        end
        if (b1_adv && wr_req)
        begin
            fwd_addr_reg <= b1_addr_reg;
            fwd_data_reg <= wr_data;
        end
        if (b1_adv)
        begin
            out_reg <= res_next;
        end
    end

    // No job leaves the queue while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clr_busy_reg |-> !pop)
        else $error("edwu_back: pop during clearing pass");

    // A write from a job is remembered for the next read
    assert property (@(posedge clk) disable iff (!rst_n)
        (b1_adv && wr_req) |=> (fwd_valid_reg
            && (fwd_addr_reg == $past(b1_addr_reg))
            && (fwd_data_reg == $past(wr_data))))
        else $error("edwu_back: forwarding register missed a write");

    // A clipped result comes from an update and sits at a range bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.saturated) |-> (out_reg.was_updated
            && ((out_reg.weight_value == WEIGHT_MAX)
             || (out_reg.weight_value == WEIGHT_MIN))))
        else $error("edwu_back: saturated result not at a bound");

endmodule

`default_nettype wire

>>> rtl/error_diffusion_weight_update.sv
// ============================================================================
// error_diffusion_weight_update: error-diffusion learning weight engine
// Loads, reads and updates signed Q8.24 weights per network, target and
// source neuron; front computes the change, back does read-modify-write.
// ============================================================================
// Path: a request passes four front stages, a queue slot, the store read and the
//   result register when nothing stalls.
// Throughput: one request per cycle while in_stall is low; the separate store
//   read and write ports plus forwarding keep same-weight updates back to back.
// Reset: the store is swept to zero, one word a cycle, all NUM_NETS * NUM_NEURONS
//   * NUM_NEURONS words (16384 by default), with in_stall high; configuration
//   writes are taken throughout.
`default_nettype none

module error_diffusion_weight_update
#(
    parameter int NUM_NETS    = edwu_pkg::EDWU_NUM_NETS,
    parameter int NUM_NEURONS = edwu_pkg::EDWU_NUM_NEURONS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire edwu_pkg::edwu_in_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output edwu_pkg::edwu_out_t       out_data
);
    import edwu_pkg::*;

    localparam int DEPTH  = NUM_NETS * NUM_NEURONS * NUM_NEURONS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0]        step_rate_reg;
    logic               bidir_mode_reg;

    logic               clearing;
    logic               queue_full;
    logic               queue_empty;
    logic               push;
    logic               pop;
    edwu_job_t          push_job;
    logic [ADDR_W-1:0]  push_addr;
    edwu_job_t          head_job;
    logic [ADDR_W-1:0]  head_addr;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_rate_reg  <= RATE_RESET;
            bidir_mode_reg <= BIDIR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_RATE:  step_rate_reg  <= cfg_data;
                CFG_BIDIR_MODE: bidir_mode_reg <= cfg_data[0];
            endcase
        end
    end

    // Accept and classify requests, compute the change
    edwu_front
    #(
        .NUM_NETS    (NUM_NETS),
        .NUM_NEURONS (NUM_NEURONS),
        .ADDR_W      (ADDR_W)
    )
    u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (clearing),
        .step_rate     (step_rate_reg),
        .bidir_mode    (bidir_mode_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .queue_full    (queue_full),
        .push          (push),
        .push_job      (push_job),
        .push_addr     (push_addr)
    );

    // Buffer jobs between front and back
    edwu_queue
    #(
        .DEPTH  (EDWU_QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .push_addr (push_addr),
        .pop       (pop),
        .head_job  (head_job),
        .head_addr (head_addr),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Apply jobs to the weight store and deliver results
    edwu_back
    #(
        .NUM_NETS    (NUM_NETS),
        .NUM_NEURONS (NUM_NEURONS),
        .ADDR_W      (ADDR_W)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .q_empty   (queue_empty),
        .q_job     (head_job),
        .q_addr    (head_addr),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> bench/tb_error_diffusion_weight_update.sv
// ============================================================================
// tb_error_diffusion_weight_update: self-checking bench of the weight engine
// Streams load, update and read requests through the valid/stall channels,
// predicts every result with a local copy of the weight store and the
// registers, and compares each result field by field in arrival order.
// ============================================================================
`default_nettype none

module tb_error_diffusion_weight_update;

    import edwu_pkg::*;

    // Command code 3 has no name in the package; the block treats it as a read
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int MEM_DEPTH      = EDWU_NUM_NETS * EDWU_NUM_NEURONS * EDWU_NUM_NEURONS;
    localparam int HOT_COUNT      = 24;
    localparam int SEG_ITEMS      = 130;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 60000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    edwu_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    edwu_out_t   out_data;

    // Local copy of the store and the registers
    logic signed [31:0] weight_mem [0:MEM_DEPTH-1];
    logic [15:0]        rate_reg;
    logic               bidir_reg;

    edwu_in_t  pending_requests [$];
    edwu_out_t pending_results [$];
    logic [13:0] hot_addr [HOT_COUNT];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int requests_accepted = 0;
    int hold_trigger = 32'h7FFF_FFFF;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int error_count = 0;
    int quiet_cycles = 0;

    error_diffusion_weight_update u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Add half then floor
    function automatic longint round_half_up(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Apply one request to the local store and return the result it gives
    function automatic edwu_out_t apply_request(edwu_in_t req);
        int unsigned addr;
        longint w, m, deriv, d24, e, act, tout, eex, einh, rate_l, ssign, tsign;
        edwu_out_t res;
        addr = (int'(req.net_index) * EDWU_NUM_NEURONS + int'(req.target_index))
               * EDWU_NUM_NEURONS + int'(req.source_index);
        res = '0;
        if (req.command == CMD_LOAD)
            weight_mem[addr] = req.load_weight;
        else if (req.command == CMD_UPDATE && weight_mem[addr] != 0)
        begin
            act    = $signed(req.source_activation);
            tout   = $signed(req.target_output);
            eex    = $signed(req.error_excite);
            einh   = $signed(req.error_inhibit);
            rate_l = rate_reg;
            ssign  = req.source_negative ? -1 : 1;
            tsign  = req.target_negative ? -1 : 1;
            m      = (tout < 0) ? -tout : tout;
            deriv  = round_half_up(m * (16384 - m), 14);
            d24    = round_half_up(rate_l * act * deriv, 16);
            if (bidir_reg)
                e = tsign * (eex - einh);
            else
                e = ((ssign > 0) ? eex : einh) * ssign * tsign;
            w = weight_mem[addr];
            w = w + round_half_up(d24 * e, 14);
            // Clip to the Q8.24 range
            if (w > 64'sd2147483647)
            begin
                w = 64'sd2147483647;
                res.saturated = 1'b1;
            end
            else if (w < -64'sd2147483648)
            begin
                w = -64'sd2147483648;
                res.saturated = 1'b1;
            end
            weight_mem[addr] = w[31:0];
            res.was_updated = 1'b1;
        end
        res.weight_value = weight_mem[addr];
        return res;
    endfunction

    // Corner values of Q2.14 in seven of twenty picks, otherwise any 16-bit pattern
    function automatic logic signed [15:0] random_q14();
        case ($urandom_range(19))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'sh4000;
            4:       return 16'shC000;
            5:       return 16'sh2000;
            6:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random request, mostly on a small set of hot connections
    function automatic edwu_in_t random_request();
        edwu_in_t r;
        logic [13:0] a;
        logic [31:0] b;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20)
            r.command = CMD_LOAD;
        else if (pick < 80)
            r.command = CMD_UPDATE;
        else if (pick < 95)
            r.command = CMD_READ;
        else
            r.command = CMD_SPARE;
        if ($urandom_range(9) == 0)
            a = 14'($urandom);
        else
            a = hot_addr[$urandom_range(HOT_COUNT - 1)];
        r.net_index    = a[13:12];
        r.target_index = a[11:6];
        r.source_index = a[5:0];
        b = $urandom;
        pick = $urandom_range(99);
        if (pick < 8)
            r.load_weight = '0;
        else if (pick < 14)
            r.load_weight = 32'h7FFF_FFFF - $urandom_range(32'h00FF_FFFF);
        else if (pick < 20)
            r.load_weight = 32'h8000_0000 + $urandom_range(32'h00FF_FFFF);
        else if (pick < 60)
            r.load_weight = {{4{b[27]}}, b[27:0]};
        else
            r.load_weight = b;
        r.source_activation = random_q14();
        r.target_output     = random_q14();
        r.error_excite      = random_q14();
        r.error_inhibit     = random_q14();
        r.source_negative   = $urandom_range(1);
        r.target_negative   = $urandom_range(1);
        return r;
    endfunction

    task automatic queue_request(input logic [1:0] cmd, input logic [1:0] net,
                                 input logic [5:0] tgt, input logic [5:0] src,
                                 input logic [31:0] w, input logic [15:0] act,
                                 input logic [15:0] tout, input logic [15:0] eex,
                                 input logic [15:0] einh, input logic sn, input logic tn);
        edwu_in_t r;
        r.command           = cmd;
        r.net_index         = net;
        r.target_index      = tgt;
        r.source_index      = src;
        r.load_weight       = w;
        r.source_activation = act;
        r.target_output     = tout;
        r.error_excite      = eex;
        r.error_inhibit     = einh;
        r.source_negative   = sn;
        r.target_negative   = tn;
        pending_requests.push_back(r);
    endtask

    // Wait until every request is sent and every result has come back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one register while the block is idle and mirror it locally
    task automatic write_register(input logic [0:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_STEP_RATE)
            rate_reg = val;
        else
            bidir_reg = val[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Request side: predict on acceptance, hold a stalled request, idle at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(apply_request(in_data));
                pending_requests.delete(0);
                requests_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_requests[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result side stall: one long hold-off, otherwise random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && requests_accepted >= hold_trigger)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        edwu_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: weight_value %0d",
                       out_data.weight_value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.weight_value !== want.weight_value)
                begin
                    $error("weight_value: expected %0d, got %0d",
                           want.weight_value, out_data.weight_value);
                    error_count++;
                end
                if (out_data.was_updated !== want.was_updated)
                begin
                    $error("was_updated: expected %0b, got %0b",
                           want.was_updated, out_data.was_updated);
                    error_count++;
                end
                if (out_data.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, out_data.saturated);
                    error_count++;
                end
            end
        end
    end

    // Abort when nothing moves for too long (covers the store clear after reset)
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_error_diffusion_weight_update: errors");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] seg_rate;
        for (int i = 0; i < MEM_DEPTH; i++)
            weight_mem[i] = '0;
        rate_reg  = RATE_RESET;
        bidir_reg = BIDIR_RESET;
        hot_addr[0] = '1;
        hot_addr[1] = '0;
        for (int i = 2; i < HOT_COUNT; i++)
            hot_addr[i] = 14'($urandom);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 37;
        recv_stall_pct = 67;

        // Directed requests under the reset configuration
        queue_request(CMD_READ,   2'd3, 6'd63, 6'd63, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd0, 6'd0, 6'd0, 32'h0, 16'h7FFF, 16'h2000, 16'h7FFF,
                      16'h0, 0, 0);
        queue_request(CMD_LOAD,   2'd0, 6'd0, 6'd0, 32'h0100_0000, 16'h0, 16'h0, 16'h0,
                      16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd0, 6'd0, 6'd0, 32'h0, 16'h4000, 16'h2000, 16'h4000,
                      16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd0, 6'd0, 6'd0, 32'h0, 16'h8000, 16'h8000, 16'h0,
                      16'h8000, 1, 0);
        queue_request(CMD_UPDATE, 2'd0, 6'd0, 6'd0, 32'h0, 16'h7FFF, 16'h7FFF, 16'h8000,
                      16'h7FFF, 0, 1);
        queue_request(CMD_READ,   2'd0, 6'd0, 6'd0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0, 0);
        queue_request(CMD_LOAD,   2'd3, 6'd63, 6'd63, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0,
                      16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd3, 6'd63, 6'd63, 32'h0, 16'h7FFF, 16'h2000, 16'h7FFF,
                      16'h0, 0, 0);
        queue_request(CMD_LOAD,   2'd2, 6'd5, 6'd9, 32'h8000_0000, 16'h0, 16'h0, 16'h0,
                      16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd2, 6'd5, 6'd9, 32'h0, 16'h7FFF, 16'h2000, 16'h8000,
                      16'h0, 0, 0);
        queue_request(CMD_SPARE,  2'd3, 6'd63, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 1, 1);
        // Load zero disables the connection; the update after it must not touch it
        queue_request(CMD_LOAD,   2'd0, 6'd0, 6'd0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd0, 6'd0, 6'd0, 32'h0, 16'h7FFF, 16'h2000, 16'h7FFF,
                      16'h0, 0, 0);
        // Update that drives the weight to exactly zero, then one on the dead link
        queue_request(CMD_LOAD,   2'd1, 6'd40, 6'd17, 32'h1, 16'h0, 16'h0, 16'h0, 16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd1, 6'd40, 6'd17, 32'h0, 16'h1, 16'h2000, 16'hFFB0,
                      16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd1, 6'd40, 6'd17, 32'h0, 16'h1, 16'h2000, 16'hFFB0,
                      16'h0, 0, 0);
        wait_drained();

        // Directed requests at the largest rate in bidirectional mode
        write_register(CFG_STEP_RATE, 16'hFFFF);
        write_register(CFG_BIDIR_MODE, 16'd1);
        queue_request(CMD_LOAD,   2'd1, 6'd1, 6'd2, 32'h0001_0000, 16'h0, 16'h0, 16'h0,
                      16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd1, 6'd1, 6'd2, 32'h0, 16'h7FFF, 16'h2000, 16'h7FFF,
                      16'h8000, 1, 0);
        queue_request(CMD_UPDATE, 2'd1, 6'd1, 6'd2, 32'h0, 16'h8000, 16'hE000, 16'h8000,
                      16'h7FFF, 0, 1);
        queue_request(CMD_UPDATE, 2'd1, 6'd1, 6'd2, 32'h0, 16'h7FFF, 16'h4000, 16'h7FFF,
                      16'h8000, 0, 0);
        queue_request(CMD_READ,   2'd1, 6'd1, 6'd2, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0, 0);
        queue_request(CMD_LOAD,   2'd2, 6'd0, 6'd63, 32'h7FFF_FFF0, 16'h0, 16'h0, 16'h0,
                      16'h0, 0, 0);
        queue_request(CMD_UPDATE, 2'd2, 6'd0, 6'd63, 32'h0, 16'h7FFF, 16'h2000, 16'h7FFF,
                      16'h8000, 0, 0);
        wait_drained();

        // Random segments, each under its own configuration; the idling pattern changes every second segment
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:       seg_rate = 16'hFFFF;
                1:       seg_rate = 16'h0000;
                2:       seg_rate = 16'h0001;
                4:       seg_rate = 16'h1000;
                default: seg_rate = 16'($urandom);
            endcase
            write_register(CFG_STEP_RATE, seg_rate);
            write_register(CFG_BIDIR_MODE, 16'(seg % 2));
            if (seg < 2)
            begin
                send_idle_pct  = 37;
                recv_stall_pct = 67;
            end
            else if (seg < 4)
            begin
                send_idle_pct  = 67;
                recv_stall_pct = 37;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // Hold off results for a long stretch while requests keep coming
            if (seg == 4)
                hold_trigger = requests_accepted + 30;
            repeat (SEG_ITEMS)
                pending_requests.push_back(random_request());
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_error_diffusion_weight_update: clean");
        else
            $display("tb_error_diffusion_weight_update: errors");
        $finish;
    end

endmodule

`default_nettype wire
